FILE: src/gbm_pkg.sv
// Package for the GHASH block multiplier: payload structs, pipeline word and
// field constants. No dependencies.
package gbm_pkg;

    localparam int unsigned GF_BITS        = 128;
    localparam int unsigned HALF_W         = 64;
    localparam logic [7:0]  REDUCE_TOP     = 8'he1;
    localparam int unsigned STEPS_PER_STAGE_DEF = 8;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
    } t_in;

    typedef struct packed {
        logic [HALF_W-1:0] product_high;
        logic [HALF_W-1:0] product_low;
    } t_out;

    // word carried down the pipeline
    typedef struct packed {
        logic [GF_BITS-1:0] acc;   // partial product
        logic [GF_BITS-1:0] mult;  // H * x^n, n = bits consumed so far
        logic [GF_BITS-1:0] xrem;  // data bits not yet consumed, next one at MSB
    } t_work;

endpackage

FILE: src/ghash_block_multiply.sv
// GHASH block multiplier, top level: key registers and the stage chain.
// Depends on gbm_pkg and gbm_stage.
//
// Multiplies each 128-bit block by the hash key H in GF(2^128), GCM bit
// order, with no chaining between blocks. H is written through the config
// port (index 0 = key_high, index 1 = key_low); both reset to zero.
// The user must write H only while idle; the block itself does not enforce it.
// The multiply is a chain of GF_BITS / STEPS_PER_STAGE stages, each consuming
// STEPS_PER_STAGE data bits; unless stalled, one block is accepted every cycle.
// The last stage register is the output register; each stage holds its item
// under backpressure and fills bubbles, so ready drops only when every stage
// is full and the output is stalled. STEPS_PER_STAGE must divide 128 (1..8).
module ghash_block_multiply #(
    parameter int unsigned STEPS_PER_STAGE = gbm_pkg::STEPS_PER_STAGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbm_pkg::HALF_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gbm_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gbm_pkg::t_out                 o_data
);
    import gbm_pkg::*;

    localparam int unsigned NUM_STAGES = GF_BITS / STEPS_PER_STAGE;

    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;

    logic  w_valid [NUM_STAGES+1];
    logic  w_ready [NUM_STAGES+1];
    t_work w_work  [NUM_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_valid[0]     = i_valid;
    assign o_ready        = w_ready[0];
    assign w_work[0].acc  = '0;
    assign w_work[0].mult = {r_key_high, r_key_low};
    assign w_work[0].xrem = {i_data.block_high, i_data.block_low};

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        gbm_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_work  (w_work[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_work  (w_work[s+1])
        );
    end

    assign w_ready[NUM_STAGES] = i_ready;
    assign o_valid             = w_valid[NUM_STAGES];
    assign o_data.product_high = w_work[NUM_STAGES].acc[GF_BITS-1 -: HALF_W];
    assign o_data.product_low  = w_work[NUM_STAGES].acc[HALF_W-1:0];

endmodule

FILE: src/gbm_stage.sv
// One pipeline stage of the GHASH multiplier: consumes STEPS data bits.
// Depends on gbm_pkg.
module gbm_stage #(
    parameter int unsigned STEPS = gbm_pkg::STEPS_PER_STAGE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gbm_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output gbm_pkg::t_work o_work
);
    import gbm_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    always_comb begin
        logic [GF_BITS-1:0] acc;
        logic [GF_BITS-1:0] mult;
        logic               carry;
        acc  = i_work.acc;
        mult = i_work.mult;
        for (int j = 0; j < STEPS; j++) begin
            if (i_work.xrem[GF_BITS-1-j]) begin
                acc = acc ^ mult;
            end
            carry = mult[0];
            mult  = mult >> 1;
            if (carry) begin
                mult[GF_BITS-1 -: 8] = mult[GF_BITS-1 -: 8] ^ REDUCE_TOP;
            end
        end
        n_work.acc  = acc;
        n_work.mult = mult;
        n_work.xrem = i_work.xrem << STEPS;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

FILE: src/gbm_checker.sv
// Port-level checks for ghash_block_multiply, attached by bind.
// Depends on gbm_pkg.
module gbm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbm_pkg::HALF_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  gbm_pkg::t_in                  i_data,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  gbm_pkg::t_out                 o_data
);
    import gbm_pkg::*;

    logic r_key_high_zero;
    logic r_key_low_zero;

    // track whether H is zero from the config writes seen on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high_zero <= 1'b1;
            r_key_low_zero  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high_zero <= (i_cfg_wdata == '0);
                REG_KEY_LOW:  r_key_low_zero  <= (i_cfg_wdata == '0);
                default: ;
            endcase
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("input transfer dropped or changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_key_high_zero && r_key_low_zero |-> o_data == '0)
        else $error("nonzero product with zero key");

    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while output side can move");

endmodule

bind ghash_block_multiply gbm_checker u_gbm_checker (.*);
